>>> rtl/core/asoa_pkg.sv
// Shared constants and types for the atom surface area estimator.
package asoa_pkg;
	localparam int RB = 12;
	localparam int SQ_W = 2 * RB;
	localparam int PROD_W = RB + SQ_W;
	localparam int AREA_W = 40;
	localparam int OUT_W = 14;
	localparam int PI_W = 18;
	localparam int FP_W = 20;
	localparam int DIV_STEPS = PROD_W;
	localparam int CNT_W = $clog2(DIV_STEPS);
	localparam logic [PI_W-1:0] PI_Q16 = PI_W'(205887);
	localparam logic [FP_W-1:0] FOUR_PI_Q16 = FP_W'(4 * 205887);
	localparam logic [OUT_W-1:0] AREA_MAX = {OUT_W{1'b1}};
	localparam logic [AREA_W:0] ROUND_HALF = (AREA_W+1)'(8192);

	typedef struct packed {
		logic [AREA_W-1:0] term;
		logic [AREA_W-1:0] sph;
		logic [AREA_W-1:0] cov;
		logic              last;
	} entry_t;
endpackage

>>> rtl/core/asoa_front.sv
// Front end: takes items and computes sphere areas and the overlap term.
module asoa_front import asoa_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [RB-1:0] atom_cov_radius,
	input  logic [RB-1:0] atom_vdw_radius,
	input  logic [RB-1:0] neighbor_vdw_radius,
	input  logic [RB-1:0] bond_length,
	input  logic          has_bond,
	input  logic          last_of_atom,
	output logic          push,
	output entry_t        push_data,
	input  logic          full
);
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SQ   = 3'd1;
	localparam logic [2:0] ST_MUL  = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_PI   = 3'd4;
	localparam logic [2:0] ST_PUSH = 3'd5;

	logic [2:0]        state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [RB-1:0]     rc_q, r1_q, r2_q, d_q;
	logic              last_q, ov_q;
	logic [SQ_W-1:0]   r1sq_q, rcsq_q, r2sq_q, gapsq_q;
	logic [AREA_W-1:0] sph_q, cov_q, term_q;
	logic [PROD_W-1:0] dvd_q;
	logic [RB-1:0]     rem_q;
	logic [RB-1:0]     diff, gap;
	logic [RB:0]       rsum, trial;
	logic              ov, take;
	logic [FP_W+SQ_W-1:0]  sph_prod, cov_prod;
	logic [PROD_W+PI_W-1:0] pi_prod;

	assign in_ready = (state_q == ST_IDLE);
	assign diff = (atom_vdw_radius > neighbor_vdw_radius) ?
		atom_vdw_radius - neighbor_vdw_radius : neighbor_vdw_radius - atom_vdw_radius;
	assign rsum = {1'b0, atom_vdw_radius} + {1'b0, neighbor_vdw_radius};
	assign ov = has_bond && (bond_length > diff) && ({1'b0, bond_length} < rsum);
	assign gap = (r1_q > d_q) ? r1_q - d_q : d_q - r1_q;
	assign sph_prod = (FP_W+SQ_W)'(FOUR_PI_Q16) * (FP_W+SQ_W)'(r1sq_q);
	assign cov_prod = (FP_W+SQ_W)'(FOUR_PI_Q16) * (FP_W+SQ_W)'(rcsq_q);
	assign trial = {rem_q, dvd_q[PROD_W-1]};
	assign take = trial >= {1'b0, d_q};
	assign pi_prod = (PROD_W+PI_W)'(dvd_q) * (PROD_W+PI_W)'(PI_Q16);

	assign push = (state_q == ST_PUSH) && !full;
	assign push_data = '{term: term_q, sph: sph_q, cov: cov_q, last: last_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: if (in_valid) state_q <= ST_SQ;
				ST_SQ:   state_q <= ST_MUL;
				ST_MUL: begin
					state_q <= ST_DIV;
					cnt_q <= '0;
				end
				ST_DIV: begin
					if (cnt_q == CNT_W'(DIV_STEPS - 1)) state_q <= ST_PI;
					cnt_q <= cnt_q + 1'b1;
				end
				ST_PI:   state_q <= ST_PUSH;
				ST_PUSH: if (!full) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				rc_q <= atom_cov_radius;
				r1_q <= atom_vdw_radius;
				r2_q <= neighbor_vdw_radius;
				d_q <= bond_length;
				last_q <= last_of_atom;
				ov_q <= ov;
			end
			ST_SQ: begin
				r1sq_q <= SQ_W'(r1_q) * SQ_W'(r1_q);
				rcsq_q <= SQ_W'(rc_q) * SQ_W'(rc_q);
				r2sq_q <= SQ_W'(r2_q) * SQ_W'(r2_q);
				gapsq_q <= SQ_W'(gap) * SQ_W'(gap);
			end
			ST_MUL: begin
				sph_q <= AREA_W'(sph_prod[FP_W+SQ_W-1:16]);
				cov_q <= AREA_W'(cov_prod[FP_W+SQ_W-1:16]);
				dvd_q <= PROD_W'(r1_q) * PROD_W'(r2sq_q - gapsq_q);
				rem_q <= '0;
			end
			ST_DIV: begin
				rem_q <= take ? RB'(trial - {1'b0, d_q}) : trial[RB-1:0];
				dvd_q <= {dvd_q[PROD_W-2:0], take};
			end
			ST_PI: term_q <= ov_q ? AREA_W'(pi_prod[PROD_W+PI_W-1:16]) : '0;
			default: ;
		endcase
	end

`ifndef NO_ASSERTIONS
	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> cnt_q < CNT_W'(DIV_STEPS)) else $error("divider overrun");
	a_push_one: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> state_q == ST_IDLE) else $error("front did not return after push");
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == ST_SQ) else $error("front missed item");
`endif
endmodule

>>> rtl/core/asoa_queue.sv
// Two-entry queue between front and back.
module asoa_queue import asoa_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_data,
	output logic   full,
	input  logic   pop,
	output entry_t head,
	output logic   not_empty
);
	entry_t     mem_q [2];
	logic       wptr_q, rptr_q;
	logic [1:0] count_q;

	assign full = count_q[1];
	assign not_empty = (count_q != 2'd0);
	assign head = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wptr_q <= !wptr_q;
			if (pop) rptr_q <= !rptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wptr_q] <= push_data;
	end

`ifndef NO_ASSERTIONS
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 2'd2) else $error("queue count out of range");
	a_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd0 || count_q == 2'd2) |-> wptr_q == rptr_q)
		else $error("queue pointers inconsistent");
	a_no_under: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty) else $error("queue underflow");
`endif
endmodule

>>> rtl/core/asoa_back.sv
// Back end: accumulates overlap terms and forms the atom's area.
module asoa_back import asoa_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             covalent_mode,
	input  logic             q_valid,
	input  entry_t           entry,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [OUT_W-1:0] surface_area
);
	logic [AREA_W-1:0] acc_q, base, nacc, pick;
	logic              inprog_q, out_valid_q;
	logic [OUT_W-1:0]  area_q;
	logic [AREA_W:0]   rounded;
	logic [AREA_W-14:0] scaled;

	assign pop = q_valid && (!out_valid_q || out_ready);
	assign base = inprog_q ? acc_q : entry.sph;
	assign nacc = (entry.term >= base) ? '0 : base - entry.term;
	assign pick = (covalent_mode || entry.cov >= nacc) ? entry.cov : nacc;
	assign rounded = {1'b0, pick} + ROUND_HALF;
	assign scaled = rounded[AREA_W:14];
	assign out_valid = out_valid_q;
	assign surface_area = area_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inprog_q <= 1'b0;
			out_valid_q <= 1'b0;
			acc_q <= '0;
		end else begin
			if (pop) begin
				acc_q <= nacc;
				inprog_q <= !entry.last;
				out_valid_q <= entry.last;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && entry.last)
			area_q <= (scaled > (AREA_W-13)'(AREA_MAX)) ? AREA_MAX : scaled[OUT_W-1:0];
	end

`ifndef NO_ASSERTIONS
	a_mid: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !entry.last |=> inprog_q) else $error("atom not kept open");
	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		pop && entry.last |=> out_valid_q && !inprog_q) else $error("atom not closed");
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		pop && inprog_q && entry.term == '0 |=> acc_q == $past(acc_q))
		else $error("accumulator moved on empty term");
`endif
endmodule

>>> rtl/core/atom_sphere_overlap_surface_area_top.sv
// Top level of the atom surface area estimator.
// Input channel (in_valid/in_ready) takes one transaction per bond of an
// atom, each carrying the atom's covalent and vdW radii, the neighbor's vdW
// radius and the bond length; last_of_atom closes the atom, and an atom
// without bonds comes as one transaction with has_bond low.
// Output channel (out_valid/out_ready) gives surface_area once per atom, on
// the transaction marked last. Config channel (cfg_valid/cfg_ready,
// cfg_data) writes covalent_mode; it is always ready.
// The front takes one transaction at a time and no new one until it is done:
// capture, square, multiply, a bit-serial divide, pi scaling and a queue push.
// A two-entry queue feeds the back, which accumulates combinationally and
// registers the area when the transaction marked last is popped.
// Reset clears the mode, the accumulator, the queue and the output valid.
// When the receiver stalls, the result holds, the queue fills and then the
// front holds its transaction until room frees up.
module atom_sphere_overlap_surface_area_top import asoa_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic             cfg_data,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [RB-1:0]    atom_cov_radius,
	input  logic [RB-1:0]    atom_vdw_radius,
	input  logic [RB-1:0]    neighbor_vdw_radius,
	input  logic [RB-1:0]    bond_length,
	input  logic             has_bond,
	input  logic             last_of_atom,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [OUT_W-1:0] surface_area
);
	logic   cmode_q;
	logic   push, full, pop, q_valid;
	entry_t push_data, head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cmode_q <= 1'b0;
		else if (cfg_valid) cmode_q <= cfg_data;
	end

	asoa_front u_front (
		.clk, .arst_n, .in_valid, .in_ready,
		.atom_cov_radius, .atom_vdw_radius, .neighbor_vdw_radius, .bond_length,
		.has_bond, .last_of_atom,
		.push, .push_data, .full
	);

	asoa_queue u_queue (
		.clk, .arst_n, .push, .push_data, .full,
		.pop, .head, .not_empty(q_valid)
	);

	asoa_back u_back (
		.clk, .arst_n, .covalent_mode(cmode_q),
		.q_valid, .entry(head), .pop,
		.out_valid, .out_ready, .surface_area
	);
endmodule
